### hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/smq_pkg.sv
package smq_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_POP    = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_COMPARE = 2'd1,
        S_UPDATE  = 2'd2
    } t_state;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } t_stat;

    localparam logic signed [31:0] EMPTY_MARK = 32'sd9999999;

endpackage

### hdl/smq_ctrl.sv
`include "assert_macros.svh"

module smq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output smq_pkg::t_cmd  o_cmd
);

    smq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smq_pkg::S_IDLE:    if (start) n_state = smq_pkg::S_COMPARE;
            smq_pkg::S_COMPARE: n_state = smq_pkg::S_UPDATE;
            smq_pkg::S_UPDATE:  n_state = smq_pkg::S_IDLE;
            default:            n_state = smq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture = (r_state == smq_pkg::S_IDLE) && start;
        o_cmd.compare = (r_state == smq_pkg::S_COMPARE);
        o_cmd.update  = (r_state == smq_pkg::S_UPDATE);
        busy          = (r_state != smq_pkg::S_IDLE);
    end

    `ASSERT_NEXT(a_cmp_then_upd, i_clk, i_rst_n, o_cmd.compare, o_cmd.update,
        "compare not followed by update")
    `ASSERT_NEXT(a_cap_busy, i_clk, i_rst_n, o_cmd.capture, busy,
        "busy not raised after capture")

endmodule

### hdl/smq_datapath.sv
`include "assert_macros.svh"

module smq_datapath #(
    parameter int CAPACITY    = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smq_pkg::t_cmd        i_cmd,
    input  logic [1:0]           i_mode,
    input  logic signed [31:0]   i_value,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_popped_value,
    output logic [21:0]          o_total_items
);

    localparam int NW     = $clog2(CAPACITY + 1);
    localparam int TW_SUM = COUNT_WIDTH + $clog2(CAPACITY) + 1;
    localparam int TW     = (TW_SUM > 22) ? TW_SUM : 22;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CONE = COUNT_WIDTH'(1);

    // Cell chain: each cell holds one value and its count, cell 0 the smallest.
    logic signed [31:0]     r_val [CAPACITY];
    logic [COUNT_WIDTH-1:0] r_cnt [CAPACITY];
    logic [NW-1:0]          r_num;
    logic [TW-1:0]          r_total;
    logic [1:0]             r_mode;
    logic signed [31:0]     r_value;
    logic [CAPACITY-1:0]    r_lt;   // cell holds a value below the operand
    logic [CAPACITY-1:0]    r_eq;   // cell holds the operand
    logic                   r_valid;
    logic [1:0]             r_status;
    logic signed [31:0]     r_popped;

    logic [CAPACITY-1:0] active;
    logic                hit, remove, grow, full, sat;
    logic [CAPACITY-1:0] sel_eq;

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            active[k] = (NW'(k) < r_num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        if (i_cmd.compare) begin
            for (int k = 0; k < CAPACITY; k++) begin
                r_lt[k] <= active[k] && (r_val[k] < r_value);
                r_eq[k] <= active[k] && (r_val[k] == r_value);
            end
        end
    end

    // For pop the operand is the head cell.
    always_comb begin
        sel_eq = r_eq;
        if (r_mode == smq_pkg::MODE_POP) begin
            sel_eq = '0;
            sel_eq[0] = (r_num != '0);
        end
        hit    = |sel_eq;
        sat    = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (sel_eq[k] && r_cnt[k] == CMAX) sat = 1'b1;
        end
        full   = (r_num == NW'(CAPACITY));
        remove = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (sel_eq[k] && r_cnt[k] == CONE) remove = 1'b1;
        end
        grow = (r_mode == smq_pkg::MODE_INSERT) && !hit && !full;
    end

    logic do_ins_cnt, do_dec;
    assign do_ins_cnt = (r_mode == smq_pkg::MODE_INSERT) && hit && !sat;
    assign do_dec = ((r_mode == smq_pkg::MODE_DELETE) || (r_mode == smq_pkg::MODE_POP)) && hit;

    // Each cell's update: keep, change count, shift from below/above, or take new.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int k = 0; k < CAPACITY; k++) begin
                if (do_ins_cnt && sel_eq[k]) begin
                    r_cnt[k] <= r_cnt[k] + CONE;
                end else if (do_dec && !remove && sel_eq[k]) begin
                    r_cnt[k] <= r_cnt[k] - CONE;
                end else if (do_dec && remove) begin
                    // Cells at and above the removed one take their upper neighbor.
                    // A pop removes the head, so every cell but the top one moves down.
                    if (k < CAPACITY - 1 && (r_mode == smq_pkg::MODE_POP || !r_lt[k])) begin
                        r_val[k] <= r_val[(k < CAPACITY - 1) ? k + 1 : k];
                        r_cnt[k] <= r_cnt[(k < CAPACITY - 1) ? k + 1 : k];
                    end
                end else if (grow && !r_lt[k]) begin
                    if (k == 0 || r_lt[(k > 0) ? k - 1 : 0]) begin
                        r_val[k] <= r_value;
                        r_cnt[k] <= CONE;
                    end else begin
                        r_val[k] <= r_val[(k > 0) ? k - 1 : 0];
                        r_cnt[k] <= r_cnt[(k > 0) ? k - 1 : 0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num   <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.update;
            if (i_cmd.update) begin
                if (grow) r_num <= r_num + NW'(1);
                if (do_dec && remove) r_num <= r_num - NW'(1);
                if (grow || do_ins_cnt) r_total <= r_total + TW'(1);
                if (do_dec) r_total <= r_total - TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            unique case (r_mode)
                smq_pkg::MODE_INSERT: begin
                    r_status <= ((hit && sat) || (!hit && full)) ? smq_pkg::ST_FULL
                                                                 : smq_pkg::ST_OK;
                    r_popped <= '0;
                end
                smq_pkg::MODE_DELETE: begin
                    r_status <= hit ? smq_pkg::ST_OK : smq_pkg::ST_NOT_FOUND;
                    r_popped <= '0;
                end
                smq_pkg::MODE_POP: begin
                    r_status <= hit ? smq_pkg::ST_OK : smq_pkg::ST_EMPTY;
                    r_popped <= hit ? r_val[0] : smq_pkg::EMPTY_MARK;
                end
                default: begin
                    r_status <= smq_pkg::ST_OK;
                    r_popped <= '0;
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_total_items  = r_total[21:0];

    `ASSERT_NEXT(a_num_bound, i_clk, i_rst_n, 1'b1, r_num <= NW'(CAPACITY),
        "entry count beyond capacity")
    `ASSERT_IMPLY(a_empty_total, i_clk, i_rst_n, r_num == '0, r_total == '0,
        "items held with no entries")

endmodule

### hdl/sorted_multiset_queue_core.sv
// Channel   Handshake           Fields
// command   start / busy        i_mode, i_value
// result    o_done (strobe)     o_status, o_popped_value, o_total_items
//
// Each operation runs through a capture step, a compare step in which
// every cell of the chain compares its value with the operand in parallel, and
// an update step in which every cell keeps, counts, or shifts one place.
// The result strobe rises in the cycle after the update; busy drops with it.
// Reset is synchronous and active low; it empties the chain at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_multiset_queue_core #(
    parameter int CAPACITY    = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic signed [31:0]  i_value,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_popped_value,
    output logic [21:0]         o_total_items
);

    smq_pkg::t_cmd cmd;

    // The controller sequences capture, compare and update.
    smq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // The datapath holds the sorted cell chain and the running totals.
    smq_datapath #(
        .CAPACITY    (CAPACITY),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_valid        (o_done),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_total_items  (o_total_items)
    );

endmodule

### bench/sorted_multiset_queue_core_tb.sv
module sorted_multiset_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = 64;
    localparam int COUNT_MAX  = 65535;

    // One expected result: the status, the popped value and the running total.
    typedef struct {
        smq_pkg::t_status    status;
        logic signed [31:0]  popped;
        logic [21:0]         total;
    } t_outcome;

    // The scoreboard keeps a sorted table of distinct values with counts and
    // works out the outcome of every operation that the block accepts.
    class multiset_scoreboard;
        int          vals[TABLE_SIZE];
        int unsigned cnts[TABLE_SIZE];
        int          used;
        int unsigned held;
        t_outcome    awaited[$];
        int          errors;

        function new();
            used   = 0;
            held   = 0;
            errors = 0;
        endfunction

        // Position of the first entry not below v.
        function int find_slot(int v);
            int i;
            i = 0;
            while (i < used && vals[i] < v) i++;
            return i;
        endfunction

        function void take_one(int pos);
            int i;
            if (cnts[pos] > 1) begin
                cnts[pos]--;
            end else begin
                for (i = pos; i + 1 < used; i++) begin
                    vals[i] = vals[i + 1];
                    cnts[i] = cnts[i + 1];
                end
                used--;
            end
            held--;
        endfunction

        function void note_command(smq_pkg::t_mode mode, logic signed [31:0] value);
            t_outcome o;
            int pos;
            int i;
            bit hit;
            o.status = smq_pkg::ST_OK;
            o.popped = '0;
            pos = find_slot(value);
            hit = (pos < used) && (vals[pos] == value);
            case (mode)
                smq_pkg::MODE_INSERT: begin
                    if (hit) begin
                        if (cnts[pos] >= COUNT_MAX) begin
                            o.status = smq_pkg::ST_FULL;
                        end else begin
                            cnts[pos]++;
                            held++;
                        end
                    end else if (used >= TABLE_SIZE) begin
                        o.status = smq_pkg::ST_FULL;
                    end else begin
                        for (i = used; i > pos; i--) begin
                            vals[i] = vals[i - 1];
                            cnts[i] = cnts[i - 1];
                        end
                        vals[pos] = value;
                        cnts[pos] = 1;
                        used++;
                        held++;
                    end
                end
                smq_pkg::MODE_DELETE: begin
                    if (hit) take_one(pos);
                    else o.status = smq_pkg::ST_NOT_FOUND;
                end
                smq_pkg::MODE_POP: begin
                    if (used == 0) begin
                        o.status = smq_pkg::ST_EMPTY;
                        o.popped = smq_pkg::EMPTY_MARK;
                    end else begin
                        o.popped = vals[0];
                        take_one(0);
                    end
                end
                default: ;
            endcase
            o.total = held[21:0];
            awaited.push_back(o);
        endfunction

        function void check_result(logic [1:0] status, logic signed [31:0] popped,
                                   logic [21:0] total);
            t_outcome o;
            if (awaited.size() == 0) begin
                $error("result with no operation outstanding");
                errors++;
                return;
            end
            o = awaited.pop_front();
            if (status !== o.status) begin
                $error("status: expected %0d, actual %0d", o.status, status);
                errors++;
            end
            if (popped !== o.popped) begin
                $error("popped_value: expected %0d, actual %0d", o.popped, popped);
                errors++;
            end
            if (total !== o.total) begin
                $error("total_items: expected %0d, actual %0d", o.total, total);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic signed [31:0] i_value;
    logic               o_done;
    logic [1:0]         o_status;
    logic signed [31:0] o_popped_value;
    logic [21:0]        o_total_items;

    multiset_scoreboard sb = new();
    int value_pool[80];
    bit gaps_on;

    sorted_multiset_queue_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_total_items  (o_total_items)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Results cannot be held off, so every strobe is checked at the edge that
    // ends its cycle. Reading at the edge sees the values from before it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_status, o_popped_value, o_total_items);
    end

    // Mostly back-to-back transfers, some short pauses and a few long ones.
    function int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Presents one command and holds it until a transfer happens, that is at
    // an edge with start high and busy low. When no pause follows, start stays
    // high so that the next call simply replaces the payload.
    task automatic send_command(smq_pkg::t_mode mode, logic signed [31:0] value);
        int gap;
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        sb.note_command(mode, value);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the command side off until every outstanding result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function logic signed [31:0] pick_value();
        if ($urandom_range(99) < 75) return value_pool[$urandom_range(79)];
        return $urandom;
    endfunction

    initial begin
        int insert_pct;
        int r;
        smq_pkg::t_mode m;
        start   <= 1'b0;
        i_mode  <= smq_pkg::MODE_INSERT;
        i_value <= '0;
        i_rst_n <= 1'b0;
        gaps_on = 1'b0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int k = 4; k < 80; k++) value_pool[k] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty pop, absent delete, unused mode, extremes,
        // repeats, removal of a last repetition and popping in order.
        send_command(smq_pkg::MODE_POP, 0);
        send_command(smq_pkg::MODE_DELETE, 5);
        send_command(smq_pkg::MODE_NONE, 32'sh7fff_ffff);
        send_command(smq_pkg::MODE_INSERT, 32'sh7fff_ffff);
        send_command(smq_pkg::MODE_INSERT, 32'sh8000_0000);
        send_command(smq_pkg::MODE_INSERT, 0);
        send_command(smq_pkg::MODE_INSERT, -1);
        send_command(smq_pkg::MODE_INSERT, 0);
        send_command(smq_pkg::MODE_INSERT, 32'sh8000_0000);
        send_command(smq_pkg::MODE_NONE, -1);
        send_command(smq_pkg::MODE_DELETE, 1);
        send_command(smq_pkg::MODE_DELETE, 0);
        send_command(smq_pkg::MODE_DELETE, -1);
        send_command(smq_pkg::MODE_DELETE, -1);
        send_command(smq_pkg::MODE_POP, 32'sh5555_5555);
        send_command(smq_pkg::MODE_POP, 32'shaaaa_aaaa);
        send_command(smq_pkg::MODE_POP, 0);
        send_command(smq_pkg::MODE_POP, 0);
        send_command(smq_pkg::MODE_POP, 0);
        send_command(smq_pkg::MODE_DELETE, 32'sh7fff_ffff);
        drain_results();

        // Fill the table with distinct values and push twice past capacity.
        for (int k = 0; k < TABLE_SIZE; k++) send_command(smq_pkg::MODE_INSERT, $urandom);
        send_command(smq_pkg::MODE_INSERT, 32'sh1234_5678);
        send_command(smq_pkg::MODE_INSERT, 32'sh8000_0000);
        for (int k = 0; k < TABLE_SIZE + 2; k++) send_command(smq_pkg::MODE_POP, 0);
        drain_results();

        // Random part in phases that lean toward growth or toward shrinking,
        // so that the table both fills up and runs dry.
        gaps_on = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            insert_pct = (ph % 2 == 0) ? 65 : 30;
            for (int k = 0; k < 300; k++) begin
                r = $urandom_range(99);
                if (r < 3) m = smq_pkg::MODE_NONE;
                else if (r < insert_pct) m = smq_pkg::MODE_INSERT;
                else if (r < insert_pct + (100 - insert_pct) / 2) m = smq_pkg::MODE_DELETE;
                else m = smq_pkg::MODE_POP;
                send_command(m, pick_value());
            end
            if (ph == 2) drain_results();
        end
        drain_results();

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: generous compared with the slowest correct run.
    initial begin
        #60ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/smq_pkg.sv
hdl/smq_ctrl.sv
hdl/smq_datapath.sv
hdl/sorted_multiset_queue_core.sv
bench/sorted_multiset_queue_core_tb.sv
